FILE: rtl/core/bfmd_pkg.sv
`default_nettype none

package bfmd_pkg;

	// Lanes of one pixel and their byte width.
	localparam int NUM_CH       = 4;
	localparam int CH_W         = 8;
	localparam int MAX_CHANNELS = 4;

	// Partial-sum store. The depth must be a power of two: the address wraps by truncation.
	localparam int SUM_DEPTH = 4096;
	localparam int ADDR_W    = $clog2(SUM_DEPTH);
	localparam int PSUM_W    = 11;
	localparam int PAIR_W    = CH_W + 1;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	// Field widths of the registers and their legal ranges.
	localparam int WIDTH_W     = 14;
	localparam int HEIGHT_W    = 14;
	localparam int DEPTH_W     = 13;
	localparam int NCH_W       = 3;
	localparam int COL_W       = 13;
	localparam int ROW_W       = 13;
	localparam int SLICE_W     = 12;
	localparam int WIDTH_MIN   = 2;
	localparam int WIDTH_MAX   = 8192;
	localparam int HEIGHT_MIN  = 1;
	localparam int HEIGHT_MAX  = 8192;
	localparam int DEPTH_MIN   = 1;
	localparam int DEPTH_MAX   = 4096;

	// Output buffer.
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = OUT_PTR_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE       = 3'd0,
		REG_CHANNELS   = 3'd1,
		REG_SRC_WIDTH  = 3'd2,
		REG_SRC_HEIGHT = 3'd3,
		REG_SRC_DEPTH  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_1D = 2'd0,
		MODE_2D = 2'd1,
		MODE_3D = 2'd2
	} mode_t;

	// What the store stage does with one horizontal pair.
	typedef enum logic [2:0] {
		OP_PAIR  = 3'd0,
		OP_LOAD  = 3'd1,
		OP_ACCUM = 3'd2,
		OP_AVG4  = 3'd3,
		OP_AVG8  = 3'd4
	} op_t;

	typedef logic [NUM_CH-1:0][PAIR_W-1:0] pair_vec_t;
	typedef logic [NUM_CH-1:0][PSUM_W-1:0] psum_word_t;
	typedef logic [NUM_CH-1:0][CH_W-1:0]   pix_vec_t;

	typedef struct packed {
		logic              valid;
		op_t               op;
		logic [ADDR_W-1:0] addr;
		pair_vec_t         ps;
		logic              last;
	} req_t;

	typedef struct packed {
		pix_vec_t px;
		logic     last;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/core/bfmd_pix_in_if.sv
`default_nettype none

interface bfmd_pix_in_if;
	import bfmd_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch0;
	logic [CH_W-1:0] ch1;
	logic [CH_W-1:0] ch2;
	logic [CH_W-1:0] ch3;

	modport source (output valid, ch0, ch1, ch2, ch3, input ready);
	modport sink (input valid, ch0, ch1, ch2, ch3, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bfmd_pix_out_if.sv
`default_nettype none

interface bfmd_pix_out_if;
	import bfmd_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] out0;
	logic [CH_W-1:0] out1;
	logic [CH_W-1:0] out2;
	logic [CH_W-1:0] out3;
	logic            last_out;

	modport source (output valid, out0, out1, out2, out3, last_out, input ready);
	modport sink (input valid, out0, out1, out2, out3, last_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bfmd_cfg_if.sv
`default_nettype none

interface bfmd_cfg_if;
	import bfmd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bfmd_ctrl.sv
`default_nettype none

module bfmd_ctrl (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	input  wire logic [bfmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bfmd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            accept,
	input  wire bfmd_pkg::pix_vec_t              ch,
	output bfmd_pkg::req_t                       req
);
	import bfmd_pkg::*;

	mode_t                mode_q;
	logic [NCH_W-1:0]     nch_q;
	logic [WIDTH_W-1:0]   width_q;
	logic [HEIGHT_W-1:0]  height_q;
	logic [DEPTH_W-1:0]   depth_q;

	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [SLICE_W-1:0]   slice_q;
	logic [ADDR_W-1:0]    base_q;
	pix_vec_t             hold_q;

	logic                 restart;
	pix_vec_t             px;
	logic [WIDTH_W-1:0]   col_inc;
	logic [HEIGHT_W-1:0]  row_inc;
	logic [DEPTH_W-1:0]   slice_inc;
	logic                 col_wrap;
	logic                 row_wrap;
	logic                 slice_wrap;
	logic [WIDTH_W-1:0]   last_col;
	logic [HEIGHT_W-1:0]  last_row;
	logic [DEPTH_W-1:0]   last_slice;
	logic [ADDR_W-1:0]    half_w;
	logic [ADDR_W-1:0]    col_addr;
	logic [1:0]           cfg_mode;
	logic [NCH_W-1:0]     cfg_nch;
	logic [WIDTH_W-1:0]   cfg_w;
	logic [DEPTH_W-1:0]   cfg_d;

	// A write to any known register restarts the image.
	always_comb begin
		restart = 1'b0;
		if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE, REG_CHANNELS, REG_SRC_WIDTH, REG_SRC_HEIGHT,
				REG_SRC_DEPTH: restart = 1'b1;
				default: restart = 1'b0;
			endcase
		end
	end

	// Register write data, clamped into the legal range as it is stored.
	assign cfg_mode = cfg_data[1:0];
	assign cfg_nch  = cfg_data[NCH_W-1:0];
	assign cfg_w    = cfg_data[WIDTH_W-1:0];
	assign cfg_d    = cfg_data[DEPTH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_2D;
			nch_q    <= NCH_W'(MAX_CHANNELS);
			width_q  <= WIDTH_W'(2);
			height_q <= HEIGHT_W'(2);
			depth_q  <= DEPTH_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE: begin
					mode_q <= (cfg_mode == 2'd3) ? MODE_3D : mode_t'(cfg_mode);
				end
				REG_CHANNELS: begin
					nch_q <= (cfg_nch > NCH_W'(MAX_CHANNELS)) ? NCH_W'(MAX_CHANNELS) : cfg_nch;
				end
				REG_SRC_WIDTH: begin
					if (cfg_w < WIDTH_W'(WIDTH_MIN)) width_q <= WIDTH_W'(WIDTH_MIN);
					else if (cfg_w > WIDTH_W'(WIDTH_MAX)) width_q <= WIDTH_W'(WIDTH_MAX);
					else width_q <= cfg_w;
				end
				REG_SRC_HEIGHT: begin
					if (cfg_w < HEIGHT_W'(HEIGHT_MIN)) height_q <= HEIGHT_W'(HEIGHT_MIN);
					else if (cfg_w > HEIGHT_W'(HEIGHT_MAX)) height_q <= HEIGHT_W'(HEIGHT_MAX);
					else height_q <= cfg_w;
				end
				REG_SRC_DEPTH: begin
					if (cfg_d < DEPTH_W'(DEPTH_MIN)) depth_q <= DEPTH_W'(DEPTH_MIN);
					else if (cfg_d > DEPTH_W'(DEPTH_MAX)) depth_q <= DEPTH_W'(DEPTH_MAX);
					else depth_q <= cfg_d;
				end
				default: ;
			endcase
		end
	end

	// Unused lanes read as zero.
	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			px[k] = (k < int'(nch_q)) ? ch[k] : '0;
		end
	end

	// Raster position and the limits of the image.
	assign col_inc    = {1'b0, col_q} + WIDTH_W'(1);
	assign row_inc    = {1'b0, row_q} + HEIGHT_W'(1);
	assign slice_inc  = {1'b0, slice_q} + DEPTH_W'(1);
	assign col_wrap   = (col_inc == width_q);
	assign row_wrap   = (row_inc == height_q);
	assign slice_wrap = (slice_inc == depth_q);
	assign last_col   = (width_q & ~WIDTH_W'(1)) - WIDTH_W'(1);
	assign last_row   = (mode_q == MODE_1D) ? height_q - HEIGHT_W'(1)
	                                        : (height_q & ~HEIGHT_W'(1)) - HEIGHT_W'(1);
	assign last_slice = (mode_q == MODE_3D) ? (depth_q & ~DEPTH_W'(1)) - DEPTH_W'(1)
	                                        : depth_q - DEPTH_W'(1);
	assign half_w     = ADDR_W'(width_q >> 1);
	assign col_addr   = ADDR_W'(col_q >> 1);

	// Request for the store stage, issued on the right pixel of each pair.
	always_comb begin
		req.valid = 1'b0;
		req.op    = OP_PAIR;
		req.addr  = '0;
		req.last  = ({1'b0, col_q} == last_col) && ({1'b0, row_q} == last_row) &&
		            ({1'b0, slice_q} == last_slice);
		for (int k = 0; k < NUM_CH; k++) begin
			req.ps[k] = {1'b0, hold_q[k]} + {1'b0, px[k]};
		end
		if (accept && col_q[0]) begin
			unique case (mode_q)
				MODE_1D: begin
					req.valid = 1'b1;
					req.op    = OP_PAIR;
				end
				MODE_2D: begin
					req.addr = col_addr;
					if (!row_q[0]) begin
						req.valid = (row_inc < height_q);
						req.op    = OP_LOAD;
					end else begin
						req.valid = 1'b1;
						req.op    = OP_AVG4;
					end
				end
				MODE_3D: begin
					req.addr  = base_q + col_addr;
					req.valid = 1'b1;
					if (!slice_q[0] && !row_q[0]) req.op = OP_LOAD;
					else if (slice_q[0] && row_q[0]) req.op = OP_AVG8;
					else req.op = OP_ACCUM;
				end
				default: req.valid = 1'b0;
			endcase
		end
	end

	// Counters, row base of the slice store and the left pixel of a pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			slice_q <= '0;
			base_q  <= '0;
			hold_q  <= '0;
		end else if (restart) begin
			col_q   <= '0;
			row_q   <= '0;
			slice_q <= '0;
			base_q  <= '0;
			hold_q  <= '0;
		end else if (accept) begin
			if (!col_q[0] && (col_inc < width_q)) begin
				hold_q <= px;
			end
			if (!col_wrap) begin
				col_q <= col_inc[COL_W-1:0];
			end else begin
				col_q <= '0;
				if (!row_wrap) begin
					row_q <= row_inc[ROW_W-1:0];
					if (row_q[0]) base_q <= base_q + half_w;
				end else begin
					row_q   <= '0;
					base_q  <= '0;
					slice_q <= slice_wrap ? '0 : slice_inc[SLICE_W-1:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/bfmd_store.sv
`default_nettype none

module bfmd_store (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bfmd_pkg::req_t req,
	output bfmd_pkg::res_t      res,
	output logic                res_valid
);
	import bfmd_pkg::*;

	psum_word_t        mem_q [SUM_DEPTH];
	psum_word_t        rd_data_s1;
	psum_word_t        fwd_data_s1;
	logic              fwd_s1;
	req_t              req_s1;

	logic              rd_en;
	logic              wr_en;
	psum_word_t        stored;
	psum_word_t        wr_data;
	logic [CH_W+1:0]   sum_pair [NUM_CH];
	logic [PSUM_W:0]   sum_blk  [NUM_CH];

	assign rd_en = req.valid &&
	               (req.op == OP_ACCUM || req.op == OP_AVG4 || req.op == OP_AVG8);
	assign wr_en = req_s1.valid && (req_s1.op == OP_LOAD || req_s1.op == OP_ACCUM);

	// Partial-sum memory: one read and one write port, read data registered.
	always_ff @(posedge clk) begin
		if (rd_en) rd_data_s1 <= mem_q[req.addr];
		if (wr_en) mem_q[req_s1.addr] <= wr_data;
	end

	// Stage one request, and a bypass when the read meets the write in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
			fwd_s1 <= 1'b0;
		end else begin
			req_s1 <= req;
			fwd_s1 <= rd_en && wr_en && (req.addr == req_s1.addr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_s1 <= wr_data;
	end

	assign stored = fwd_s1 ? fwd_data_s1 : rd_data_s1;

	// Modify the entry and round the averages.
	always_comb begin
		res.last = req_s1.last;
		for (int k = 0; k < NUM_CH; k++) begin
			sum_pair[k] = {1'b0, req_s1.ps[k]} + (CH_W+2)'(1);
			sum_blk[k]  = {1'b0, stored[k]} + (PSUM_W+1)'(req_s1.ps[k]) +
			              ((req_s1.op == OP_AVG8) ? (PSUM_W+1)'(4) : (PSUM_W+1)'(2));
			wr_data[k]  = (req_s1.op == OP_LOAD) ? PSUM_W'(req_s1.ps[k])
			                                     : PSUM_W'(stored[k] + PSUM_W'(req_s1.ps[k]));
			unique case (req_s1.op)
				OP_AVG4: res.px[k] = sum_blk[k][CH_W+1:2];
				OP_AVG8: res.px[k] = sum_blk[k][CH_W+2:3];
				default: res.px[k] = sum_pair[k][CH_W:1];
			endcase
		end
	end

	assign res_valid = req_s1.valid &&
	                   (req_s1.op == OP_PAIR || req_s1.op == OP_AVG4 || req_s1.op == OP_AVG8);

endmodule

`default_nettype wire

FILE: rtl/core/bfmd_out_buf.sv
`default_nettype none

module bfmd_out_buf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire bfmd_pkg::res_t push_data,
	input  wire logic           pending,
	output logic                room,
	output logic                out_valid,
	input  wire logic           out_ready,
	output bfmd_pkg::res_t      out_data
);
	import bfmd_pkg::*;

	res_t                  slot_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]  wr_ptr_q;
	logic [OUT_PTR_W-1:0]  rd_ptr_q;
	logic [OUT_CNT_W-1:0]  count_q;
	logic                  pop;

	assign out_valid = (count_q != '0);
	assign out_data  = slot_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// A new pixel is taken only if its result and the one in flight both fit.
	assign room = ((OUT_CNT_W+1)'(count_q) + (OUT_CNT_W+1)'(pending)) <
	              (OUT_CNT_W+1)'(OUT_DEPTH);

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			count_q <= count_q + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/box_filter_mipmap_downsampler.sv
// Channel   Role    Request
// src       sink    one source pixel, ch0..ch3, raster order
// dst       source  one averaged pixel, out0..out3 and last_out
// cfg       sink    register write, index and data; always ready
//
// One source pixel is taken per cycle while src is not stalled; a result passes
// through the store stage request register and the output buffer before dst offers
// it. The partial-sum memory does one read and one write per cycle, with a bypass
// for back-to-back use of an entry. Reset clears counters and the buffer; the
// memory is not cleared, every entry is written before it is read. src stalls only
// when the four-entry output buffer could not hold the results already under way.
`default_nettype none

module box_filter_mipmap_downsampler (
	input  wire logic      clk,
	input  wire logic      arst_n,
	bfmd_pix_in_if.sink    src,
	bfmd_pix_out_if.source dst,
	bfmd_cfg_if.sink       cfg
);
	import bfmd_pkg::*;

	logic     accept;
	logic     room;
	logic     res_valid;
	pix_vec_t ch;
	req_t     req;
	res_t     res;
	res_t     out_data;

	assign cfg.ready = 1'b1;
	assign src.ready = room;
	assign accept    = src.valid && room;

	assign ch[0] = src.ch0;
	assign ch[1] = src.ch1;
	assign ch[2] = src.ch2;
	assign ch[3] = src.ch3;

	// Counters, pair hold and address generation.
	bfmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.accept    (accept),
		.ch        (ch),
		.req       (req)
	);

	// Read-modify-write of the partial sums and rounding.
	bfmd_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.res_valid (res_valid)
	);

	// Output buffer between the store stage and the sink.
	bfmd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pending   (res_valid),
		.room      (room),
		.out_valid (dst.valid),
		.out_ready (dst.ready),
		.out_data  (out_data)
	);

	assign dst.out0     = out_data.px[0];
	assign dst.out1     = out_data.px[1];
	assign dst.out2     = out_data.px[2];
	assign dst.out3     = out_data.px[3];
	assign dst.last_out = out_data.last;

endmodule

`default_nettype wire
